FILE: rtl/core/ps2m_pkg.sv
// ----------------------------------------------------------------------------
// ps2m_pkg
// Constants and helpers for the PS/2 mouse packet decoder: byte flag
// positions, configuration register indexes, reset values and axis clamp.
// ----------------------------------------------------------------------------
package ps2m_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 15;

  localparam logic [CFG_IDX_W-1:0] CFG_WHEEL_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd2;

  // Bit positions in the first (flags) byte of a packet
  localparam int SYNC_BIT  = 3;
  localparam int XSIGN_BIT = 4;
  localparam int YSIGN_BIT = 5;
  localparam int BTN_W     = 3;

  // Byte positions within a packet
  localparam logic [1:0] IDX_FIRST  = 2'd0;
  localparam logic [1:0] IDX_DY     = 2'd2;
  localparam logic [1:0] IDX_WHEEL  = 2'd3;

  // Reset values
  localparam logic [14:0] WIDTH_RST    = 15'd1024;
  localparam logic [14:0] HEIGHT_RST   = 15'd768;
  localparam logic [31:0] CURSOR_X_RST = 32'd512;
  localparam logic [31:0] CURSOR_Y_RST = 32'd384;

  // Clamp a 32-bit two's complement coordinate into [0, limit-1]
  function automatic logic [31:0] clamp_axis(input logic [31:0] v,
                                             input logic [14:0] limit);
    logic [31:0] lim32;
    lim32 = {17'd0, limit};
    if (v[31]) begin
      clamp_axis = 32'd0;
    end else if (v >= lim32) begin
      clamp_axis = lim32 - 32'd1;
    end else begin
      clamp_axis = v;
    end
  endfunction

endpackage

FILE: rtl/core/ps2_mouse_packet_decoder.sv
// ----------------------------------------------------------------------------
// ps2_mouse_packet_decoder
// Frames PS/2 mouse bytes into 3- or 4-byte packets, tracks a clamped
// cursor and button state, and emits one event item per changed packet.
// ----------------------------------------------------------------------------
// An event is registered and presented the cycle after its last byte is taken.
// Throughput: one byte per cycle; the single output register stalls input
//   only while a pending event is not being taken.
// Reset (rst_n low, synchronous): byte framing restarts, cursor goes to
//   (512, 384), buttons and drop count clear, registers take their defaults.
module ps2_mouse_packet_decoder (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [ps2m_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ps2m_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // byte input
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [7:0]                          in_data_byte,
  // event output
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [8:0]                   out_delta_x,
  output logic signed [9:0]                   out_delta_y,
  output logic signed [15:0]                  out_pos_x,
  output logic signed [15:0]                  out_pos_y,
  output logic signed [3:0]                   out_wheel_delta,
  output logic [2:0]                          out_button_bits,
  output logic [2:0]                          out_pressed_bits,
  output logic [2:0]                          out_released_bits,
  output logic [31:0]                         out_sync_drops
);
  import ps2m_pkg::*;

  // Configuration registers
  logic        wheel_mode_r;
  logic [14:0] width_r;
  logic [14:0] height_r;

  // Decoder state
  logic [1:0]       byte_index_r, byte_index_nxt;
  logic [7:0]       pkt0_r, pkt1_r, pkt2_r;
  logic [31:0]      cursor_x_r, cursor_x_nxt;
  logic [31:0]      cursor_y_r, cursor_y_nxt;
  logic [BTN_W-1:0] button_r;
  logic [31:0]      drop_count_r;

  // Output register
  logic              out_valid_r;
  logic signed [8:0] delta_x_r;
  logic signed [9:0] delta_y_r;
  logic [15:0]       pos_x_r, pos_y_r;
  logic [3:0]        wheel_r;
  logic [BTN_W-1:0]  btn_out_r, pressed_r, released_r;
  logic [31:0]       drops_r;

  // Per-byte decode
  logic             in_fire;
  logic [1:0]       last_idx;
  logic             is_drop;
  logic             pkt_end;
  logic [7:0]       dy_byte;
  logic [8:0]       dx9, dy9;
  logic [31:0]      dx32, dy32, sum_x, sum_y;
  logic [3:0]       wheel;
  logic [BTN_W-1:0] new_btn;
  logic             clamp_en;
  logic             has_result;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Configuration writes; unused index is ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wheel_mode_r <= 1'b0;
      width_r      <= WIDTH_RST;
      height_r     <= HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WHEEL_MODE:    wheel_mode_r <= cfg_wdata[0];
        CFG_SCREEN_WIDTH:  width_r      <= cfg_wdata;
        CFG_SCREEN_HEIGHT: height_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Framing and packet arithmetic
  always_comb begin
    last_idx = wheel_mode_r ? IDX_WHEEL : IDX_DY;
    is_drop  = (byte_index_r == IDX_FIRST) && !in_data_byte[SYNC_BIT];
    pkt_end  = !is_drop && (byte_index_r >= last_idx);

    // dy byte comes straight from the input on a 3-byte packet end
    dy_byte = (byte_index_r == IDX_DY) ? in_data_byte : pkt2_r;
    dx9     = {pkt0_r[XSIGN_BIT], pkt1_r};
    dy9     = {pkt0_r[YSIGN_BIT], dy_byte};
    dx32    = {{23{dx9[8]}}, dx9};
    dy32    = {{23{dy9[8]}}, dy9};
    wheel   = (wheel_mode_r && (byte_index_r == IDX_WHEEL)) ? in_data_byte[3:0] : 4'd0;
    new_btn = pkt0_r[BTN_W-1:0];

    sum_x    = cursor_x_r + dx32;
    sum_y    = cursor_y_r - dy32;
    clamp_en = (width_r != 15'd0) && (height_r != 15'd0);
    cursor_x_nxt = clamp_en ? clamp_axis(sum_x, width_r)  : sum_x;
    cursor_y_nxt = clamp_en ? clamp_axis(sum_y, height_r) : sum_y;

    has_result = pkt_end && ((dx9 != 9'd0) || (dy9 != 9'd0) || (wheel != 4'd0) ||
                             (button_r != new_btn));

    if (is_drop || pkt_end) begin
      byte_index_nxt = IDX_FIRST;
    end else begin
      byte_index_nxt = byte_index_r + 2'd1;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_index_r <= IDX_FIRST;
      cursor_x_r   <= CURSOR_X_RST;
      cursor_y_r   <= CURSOR_Y_RST;
      button_r     <= '0;
      drop_count_r <= '0;
    end else if (in_fire) begin
      byte_index_r <= byte_index_nxt;
      if (is_drop) begin
        drop_count_r <= drop_count_r + 32'd1;
      end
      if (pkt_end) begin
        cursor_x_r <= cursor_x_nxt;
        cursor_y_r <= cursor_y_nxt;
        button_r   <= new_btn;
      end
    end
  end

  // Packet byte buffer (no reset: read only after written)
  always_ff @(posedge clk) begin
    if (in_fire && !is_drop && !pkt_end) begin
      case (byte_index_r)
        2'd0:    pkt0_r <= in_data_byte;
        2'd1:    pkt1_r <= in_data_byte;
        default: pkt2_r <= in_data_byte;
      endcase
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire && has_result) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (in_fire && has_result) begin
      delta_x_r  <= dx9;
      delta_y_r  <= 10'd0 - {dy9[8], dy9};
      pos_x_r    <= cursor_x_nxt[15:0];
      pos_y_r    <= cursor_y_nxt[15:0];
      wheel_r    <= wheel;
      btn_out_r  <= new_btn;
      pressed_r  <= ~button_r & new_btn;
      released_r <= button_r & ~new_btn;
      drops_r    <= drop_count_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_delta_x       = delta_x_r;
  assign out_delta_y       = delta_y_r;
  assign out_pos_x         = pos_x_r;
  assign out_pos_y         = pos_y_r;
  assign out_wheel_delta   = wheel_r;
  assign out_button_bits   = btn_out_r;
  assign out_pressed_bits  = pressed_r;
  assign out_released_bits = released_r;
  assign out_sync_drops    = drops_r;

  // Assertions
  a_clamp_x: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && pkt_end && clamp_en |=>
      !cursor_x_r[31] && (cursor_x_r < {17'd0, width_r}))
    else $error("cursor x outside clamp range");

  a_clamp_y: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && pkt_end && clamp_en |=>
      !cursor_y_r[31] && (cursor_y_r < {17'd0, height_r}))
    else $error("cursor y outside clamp range");

  a_drop_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && is_drop |=> (drop_count_r == $past(drop_count_r) + 32'd1) &&
      (byte_index_r == IDX_FIRST))
    else $error("dropped byte not counted");

  a_btn_edges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((pressed_r & released_r) == '0) &&
      ((pressed_r & ~btn_out_r) == '0) && ((released_r & btn_out_r) == '0))
    else $error("button edge bits inconsistent");

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the PS/2 mouse packet decoder. Bytes go in over a
// valid/ready channel, a behavioral tracker of framing, cursor and buttons
// predicts each event item, and a monitor compares every event taken at the
// output against the oldest prediction. Directed checks come first, then
// random packet traffic under several register settings and idle patterns.
// ----------------------------------------------------------------------------
module tb_top;
  import ps2m_pkg::*;

  localparam int                   DRAIN_CYCLES = 4;
  localparam int                   TIMEOUT_TU   = 12 * 400000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED   = 2'd3;

  typedef struct packed {
    logic signed [8:0]  dx;
    logic signed [9:0]  dy;
    logic signed [15:0] px;
    logic signed [15:0] py;
    logic signed [3:0]  wheel;
    logic [2:0]         btn;
    logic [2:0]         pressed;
    logic [2:0]         released;
    logic [31:0]        drops;
  } ps2_item_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_data_byte = 8'h00;

  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [8:0]  out_delta_x;
  logic signed [9:0]  out_delta_y;
  logic signed [15:0] out_pos_x;
  logic signed [15:0] out_pos_y;
  logic signed [3:0]  out_wheel_delta;
  logic [2:0]         out_button_bits;
  logic [2:0]         out_pressed_bits;
  logic [2:0]         out_released_bits;
  logic [31:0]        out_sync_drops;

  // Tracker state, mirrors the decoder
  logic        trk_wheel_mode = 1'b0;
  logic [14:0] trk_width      = WIDTH_RST;
  logic [14:0] trk_height     = HEIGHT_RST;
  logic [1:0]  trk_idx        = IDX_FIRST;
  logic [7:0]  trk_pkt [0:2];
  logic [31:0] trk_cx         = CURSOR_X_RST;
  logic [31:0] trk_cy         = CURSOR_Y_RST;
  logic [2:0]  trk_btn        = 3'd0;
  logic [31:0] trk_drops      = 32'd0;

  ps2_item_t pending_events[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int n_sent         = 0;
  int n_err          = 0;

  ps2_mouse_packet_decoder u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_delta_x      (out_delta_x),
    .out_delta_y      (out_delta_y),
    .out_pos_x        (out_pos_x),
    .out_pos_y        (out_pos_y),
    .out_wheel_delta  (out_wheel_delta),
    .out_button_bits  (out_button_bits),
    .out_pressed_bits (out_pressed_bits),
    .out_released_bits(out_released_bits),
    .out_sync_drops   (out_sync_drops)
  );

  always #6 clk = ~clk;

  // Coordinate limit: negative goes to 0, at or past the edge to edge - 1
  function automatic logic [31:0] limit_coord(input logic [31:0] v,
                                              input logic [14:0] lim);
    if (v[31]) return 32'd0;
    if (v >= {17'd0, lim}) return {17'd0, lim} - 32'd1;
    return v;
  endfunction

  // Advance the tracker by one accepted byte, queue the event it causes
  function automatic void track_byte(input logic [7:0] b);
    logic [1:0]   cur;
    logic [1:0]   end_idx;
    logic [31:0]  dx;
    logic [31:0]  dy;
    logic [31:0]  ndy;
    logic [3:0]   wh;
    logic [2:0]   old_btn;
    logic [2:0]   new_btn;
    ps2_item_t    ev;
    cur     = trk_idx;
    end_idx = trk_wheel_mode ? IDX_WHEEL : IDX_DY;
    if (cur == IDX_FIRST && !b[SYNC_BIT]) begin
      trk_drops = trk_drops + 32'd1;
      return;
    end
    if (cur < end_idx) begin
      trk_pkt[cur] = b;
      trk_idx      = cur + 2'd1;
      return;
    end
    // last byte of the packet; a fourth byte after a mode drop is discarded
    if (cur != IDX_WHEEL) trk_pkt[cur] = b;
    trk_idx = IDX_FIRST;
    dx = {{24{trk_pkt[0][XSIGN_BIT]}}, trk_pkt[1]};
    dy = {{24{trk_pkt[0][YSIGN_BIT]}}, trk_pkt[2]};
    wh = (trk_wheel_mode && cur == IDX_WHEEL) ? b[3:0] : 4'd0;
    old_btn = trk_btn;
    new_btn = trk_pkt[0][BTN_W-1:0];
    trk_btn = new_btn;
    trk_cx  = trk_cx + dx;
    trk_cy  = trk_cy - dy;
    if (trk_width != 15'd0 && trk_height != 15'd0) begin
      trk_cx = limit_coord(trk_cx, trk_width);
      trk_cy = limit_coord(trk_cy, trk_height);
    end
    // quiet packet: state moves on, no event
    if (dx == 32'd0 && dy == 32'd0 && wh == 4'd0 && old_btn == new_btn) return;
    ndy         = 32'd0 - dy;
    ev.dx       = dx[8:0];
    ev.dy       = ndy[9:0];
    ev.px       = trk_cx[15:0];
    ev.py       = trk_cy[15:0];
    ev.wheel    = wh;
    ev.btn      = new_btn;
    ev.pressed  = ~old_btn & new_btn;
    ev.released = old_btn & ~new_btn;
    ev.drops    = trk_drops;
    pending_events.push_back(ev);
  endfunction

  function automatic string fmt_event(input ps2_item_t ev);
    return $sformatf("dx=%0d dy=%0d x=%0d y=%0d wh=%0d btn=%0h prs=%0h rel=%0h drops=%0d",
                     ev.dx, ev.dy, ev.px, ev.py, ev.wheel, ev.btn, ev.pressed,
                     ev.released, ev.drops);
  endfunction

  // Event monitor and output stall generator
  always @(posedge clk) begin
    ps2_item_t got;
    ps2_item_t want;
    logic      bad;
    if (rst_n && out_valid && out_ready) begin
      got.dx       = out_delta_x;
      got.dy       = out_delta_y;
      got.px       = out_pos_x;
      got.py       = out_pos_y;
      got.wheel    = out_wheel_delta;
      got.btn      = out_button_bits;
      got.pressed  = out_pressed_bits;
      got.released = out_released_bits;
      got.drops    = out_sync_drops;
      if (pending_events.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("ERROR: event with none expected: %s", fmt_event(got));
      end else begin
        want = pending_events.pop_front();
        bad = (got.dx !== want.dx) || (got.dy !== want.dy) || (got.px !== want.px) ||
              (got.py !== want.py) || (got.wheel !== want.wheel) ||
              (got.btn !== want.btn) || (got.pressed !== want.pressed) ||
              (got.released !== want.released) || (got.drops !== want.drops);
        if (bad) begin
          n_err++;
          if (n_err <= 10) begin
            $display("ERROR: event mismatch");
            $display("  expected %s", fmt_event(want));
            $display("  actual   %s", fmt_event(got));
          end
        end
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Send one byte; valid stays high after acceptance unless a gap follows
  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
    track_byte(b);
  endtask

  // Stop sending and wait until the decoder has nothing left to deliver
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_WHEEL_MODE:    trk_wheel_mode = val[0];
      CFG_SCREEN_WIDTH:  trk_width      = val;
      CFG_SCREEN_HEIGHT: trk_height     = val;
      default: begin end
    endcase
  endtask

  // Motion byte biased toward tiny moves and the range ends
  function automatic logic [7:0] pick_delta();
    int r;
    r = $urandom_range(99);
    if (r < 25) return 8'($urandom_range(3));
    if (r < 40) return 8'hFF - 8'($urandom_range(3));
    if (r < 55) begin
      case ($urandom_range(3))
        0:       return 8'h00;
        1:       return 8'h7F;
        2:       return 8'h80;
        default: return 8'hFF;
      endcase
    end
    return 8'($urandom);
  endfunction

  task automatic send_random_packet();
    logic [7:0] flags;
    logic [7:0] bx;
    logic [7:0] by;
    logic [7:0] bw;
    flags = 8'($urandom);
    flags[SYNC_BIT] = 1'b1;
    bx = pick_delta();
    by = pick_delta();
    bw = 8'($urandom);
    // occasional quiet packet: no motion, no wheel, same buttons
    if ($urandom_range(9) == 0) begin
      flags[XSIGN_BIT] = 1'b0;
      flags[YSIGN_BIT] = 1'b0;
      flags[2:0]       = trk_btn;
      bx               = 8'h00;
      by               = 8'h00;
      bw[3:0]          = 4'h0;
    end
    send_byte(flags);
    send_byte(bx);
    send_byte(by);
    if (trk_wheel_mode) send_byte(bw);
  endtask

  // Reset defaults, sync drops, sign extension, buttons, overflow bits
  task automatic test_sync_and_signs();
    send_byte(8'h00);
    send_byte(8'hF7);
    send_byte(8'h08); send_byte(8'h00); send_byte(8'h00);
    send_byte(8'h09); send_byte(8'hFF); send_byte(8'h01);
    send_byte(8'h3E); send_byte(8'h00); send_byte(8'h00);
    send_byte(8'hC8); send_byte(8'h80); send_byte(8'h80);
    settle();
  endtask

  // Wheel packets, then a mode drop with three bytes buffered
  task automatic test_wheel_and_mode_drop();
    write_reg(CFG_WHEEL_MODE, 15'h4001);
    send_byte(8'h08); send_byte(8'h00); send_byte(8'h00); send_byte(8'h0F);
    send_byte(8'h0C); send_byte(8'h00); send_byte(8'h00); send_byte(8'hF8);
    send_byte(8'h09); send_byte(8'h10); send_byte(8'h20);
    settle();
    write_reg(CFG_WHEEL_MODE, 15'h0000);
    send_byte(8'hA5);
    settle();
  endtask

  // Tiny screen clamp and a write to the unused register index
  task automatic test_clamp_and_unused_index();
    write_reg(CFG_SCREEN_WIDTH, 15'd1);
    write_reg(CFG_SCREEN_HEIGHT, 15'd1);
    write_reg(CFG_UNUSED, 15'h7FFF);
    send_byte(8'h18); send_byte(8'h05); send_byte(8'hFB);
    settle();
  endtask

  // Random packets with noise and broken starts; wheel mode redrawn when idle
  task automatic test_random_traffic(input int n_bytes, input int send_pct,
                                     input int stall_pct, input logic mode,
                                     input logic [14:0] w, input logic [14:0] h);
    int          stop_at;
    int          next_flip;
    int          r;
    logic [7:0]  f;
    logic [14:0] v;
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    v    = 15'($urandom);
    v[0] = mode;
    write_reg(CFG_WHEEL_MODE, v);
    write_reg(CFG_SCREEN_WIDTH, w);
    write_reg(CFG_SCREEN_HEIGHT, h);
    stop_at   = n_sent + n_bytes;
    next_flip = n_sent + 120;
    while (n_sent < stop_at) begin
      if (n_sent >= next_flip) begin
        settle();
        v = 15'($urandom);
        write_reg(CFG_WHEEL_MODE, v);
        next_flip = n_sent + 120;
      end
      r = $urandom_range(99);
      if (r < 85) begin
        send_random_packet();
      end else if (r < 93) begin
        send_byte(8'($urandom));
      end else begin
        f = 8'($urandom);
        f[SYNC_BIT] = 1'b1;
        send_byte(f);
        if ($urandom_range(1) == 1) send_byte(pick_delta());
      end
    end
    settle();
  endtask

  initial begin
    send_idle_pct  = 25;
    recv_stall_pct = 25;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_sync_and_signs();
    test_wheel_and_mode_drop();
    test_clamp_and_unused_index();
    test_random_traffic(375, 0, 0, 1'b1, 15'd32767, 15'd32767);
    test_random_traffic(375, 85, 0, 1'b0, 15'd0, 15'd0);
    test_random_traffic(375, 0, 85, 1'b1, 15'd700, 15'd1);
    test_random_traffic(375, 8, 8, 1'b0, 15'd640, 15'd0);
    if (n_err == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_TU);
    $display("ERROR: timeout");
    $display("*** FAILED ***");
    $finish;
  end

endmodule
